// ===== hw/rtl/rds_pkg.sv =====
// Package for the reaction-diffusion stencil: widths, register indexes,
// reset values, controller state and command types.
// No dependencies.
`default_nettype none

package rds_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int DATA_W     = 16;
	localparam int COEF_W     = 16;
	localparam int CFG_DIM_W  = 11;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEED        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KILL        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION_U = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION_V = 3'd5;

	localparam logic [CFG_DIM_W-1:0] GRID_WIDTH_RST  = 11'd1024;
	localparam logic [CFG_DIM_W-1:0] GRID_HEIGHT_RST = 11'd1024;
	localparam logic [COEF_W-1:0]    FEED_RST        = 16'd918;
	localparam logic [COEF_W-1:0]    KILL_RST        = 16'd3539;
	localparam logic [COEF_W-1:0]    DIFF_U_RST      = 16'd6554;
	localparam logic [COEF_W-1:0]    DIFF_V_RST      = 16'd3277;

	// smallest grid dimension, first position where a full window exists
	localparam int DIM_MIN        = 3;
	localparam int FIRST_EMIT_POS = 2;

	// Q4.12 one, and saturation bounds
	localparam int ONE_Q12 = 4096;
	localparam int Q_MAX   = 32767;
	localparam int Q_MIN   = -32768;

	// arithmetic widths
	localparam int LAP_W   = 20;
	localparam int UV_W    = 32;
	localparam int FU_W    = 34;
	localparam int DL_W    = 37;
	localparam int UVV_W   = 48;
	localparam int DELTA_W = 50;
	localparam int FIN_W   = 52;
	localparam int FRAC_SH = 24;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WIN,
		ST_LAP,
		ST_MUL,
		ST_SUM,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic win;
		logic lap;
		logic mul;
		logic sum;
		logic fin;
		logic load_out;
		logic last;
	} cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rds_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rds_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rds_datapath.sv =====
// Datapath: line store RAM, 3x3 windows, Laplacian, Gray-Scott update,
// rounding, saturation and output register. Depends on rds_pkg, rds_ram.
`default_nettype none

module rds_datapath
	import rds_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cmd_t                         cmd,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] col,
	input  wire logic signed [DATA_W-1:0]     u_in,
	input  wire logic signed [DATA_W-1:0]     v_in,
	input  wire logic [COEF_W-1:0]            f_coef,
	input  wire logic [COEF_W-1:0]            k_coef,
	input  wire logic [COEF_W-1:0]            diffusion_u,
	input  wire logic [COEF_W-1:0]            diffusion_v,
	output      logic signed [DATA_W-1:0]     u_next,
	output      logic signed [DATA_W-1:0]     v_next,
	output      logic                         last_in_frame
);

	localparam int RAM_W = 4 * DATA_W;

	logic signed [DATA_W-1:0] in_u_q, in_v_q;
	logic signed [DATA_W-1:0] uw_q [9];
	logic signed [DATA_W-1:0] vw_q [9];
	logic [RAM_W-1:0]         rd_data, wr_data;
	logic signed [DATA_W-1:0] u_row0, u_row1, v_row0, v_row1;

	logic signed [LAP_W-1:0]   lap_u, lap_v, lap_u_q, lap_v_q;
	logic signed [UV_W-1:0]    uv_q;
	logic signed [FU_W-1:0]    fu_q, fkv_q;
	logic signed [DL_W-1:0]    dlu_q, dlv_q;
	logic signed [UVV_W-1:0]   uvv_q;
	logic signed [DELTA_W-1:0] du_q, dv_q;
	logic signed [FIN_W-1:0]   tu, tv, ru, rv;
	logic signed [DATA_W-1:0]  su, sv, res_u_q, res_v_q;
	logic signed [DATA_W:0]    one_minus_u;
	logic [COEF_W:0]           fk_sum;
	logic signed [DATA_W-1:0]  u_out_q, v_out_q;
	logic                      last_out_q;

	// {row two up, row one up} for u then v
	assign {u_row0, u_row1, v_row0, v_row1} = rd_data;
	assign wr_data = {u_row1, in_u_q, v_row1, in_v_q};

	rds_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (cmd.win),
		.waddr(col),
		.wdata(wr_data),
		.re   (cmd.capture),
		.raddr(col),
		.rdata(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_u_q <= u_in;
			in_v_q <= v_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				uw_q[i] <= '0;
				vw_q[i] <= '0;
			end
		end else if (cmd.win) begin
			for (int k = 0; k < 3; k++) begin
				uw_q[k*3]   <= uw_q[k*3+1];
				uw_q[k*3+1] <= uw_q[k*3+2];
				vw_q[k*3]   <= vw_q[k*3+1];
				vw_q[k*3+1] <= vw_q[k*3+2];
			end
			uw_q[2] <= u_row0;
			uw_q[5] <= u_row1;
			uw_q[8] <= in_u_q;
			vw_q[2] <= v_row0;
			vw_q[5] <= v_row1;
			vw_q[8] <= in_v_q;
		end
	end

	// neighbour sum minus eight times the centre
	always_comb begin
		lap_u = -(LAP_W'(uw_q[4]) <<< 3);
		lap_v = -(LAP_W'(vw_q[4]) <<< 3);
		for (int i = 0; i < 9; i++) begin
			if (i != 4) begin
				lap_u = lap_u + LAP_W'(uw_q[i]);
				lap_v = lap_v + LAP_W'(vw_q[i]);
			end
		end
	end

	assign one_minus_u = (DATA_W+1)'(ONE_Q12) - (DATA_W+1)'(uw_q[4]);
	assign fk_sum      = {1'b0, f_coef} + {1'b0, k_coef};

	always_ff @(posedge clk) begin
		if (cmd.lap) begin
			lap_u_q <= lap_u;
			lap_v_q <= lap_v;
			uv_q    <= UV_W'(uw_q[4]) * UV_W'(vw_q[4]);
			fu_q    <= FU_W'($signed({1'b0, f_coef})) * FU_W'(one_minus_u);
			fkv_q   <= FU_W'($signed({1'b0, fk_sum})) * FU_W'(vw_q[4]);
		end
		if (cmd.mul) begin
			dlu_q <= DL_W'($signed({1'b0, diffusion_u})) * DL_W'(lap_u_q);
			dlv_q <= DL_W'($signed({1'b0, diffusion_v})) * DL_W'(lap_v_q);
			uvv_q <= UVV_W'(uv_q) * UVV_W'(vw_q[4]);
		end
		if (cmd.sum) begin
			du_q <= (DELTA_W'(dlu_q) <<< 8) - DELTA_W'(uvv_q) + (DELTA_W'(fu_q) <<< 8);
			dv_q <= (DELTA_W'(dlv_q) <<< 8) + DELTA_W'(uvv_q) - (DELTA_W'(fkv_q) <<< 8);
		end
		if (cmd.fin) begin
			res_u_q <= su;
			res_v_q <= sv;
		end
	end

	// round half up at Q.24, then saturate to Q4.12
	always_comb begin
		tu = (FIN_W'(uw_q[4]) <<< FRAC_SH) + FIN_W'(du_q) + (FIN_W'(1) <<< (FRAC_SH - 1));
		tv = (FIN_W'(vw_q[4]) <<< FRAC_SH) + FIN_W'(dv_q) + (FIN_W'(1) <<< (FRAC_SH - 1));
		ru = tu >>> FRAC_SH;
		rv = tv >>> FRAC_SH;
		priority if (ru > FIN_W'(Q_MAX)) begin
			su = DATA_W'(Q_MAX);
		end else if (ru < FIN_W'(Q_MIN)) begin
			su = DATA_W'(Q_MIN);
		end else begin
			su = ru[DATA_W-1:0];
		end
		priority if (rv > FIN_W'(Q_MAX)) begin
			sv = DATA_W'(Q_MAX);
		end else if (rv < FIN_W'(Q_MIN)) begin
			sv = DATA_W'(Q_MIN);
		end else begin
			sv = rv[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			u_out_q    <= res_u_q;
			v_out_q    <= res_v_q;
			last_out_q <= cmd.last;
		end
	end

	assign u_next        = u_out_q;
	assign v_next        = v_out_q;
	assign last_in_frame = last_out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rds_ctrl.sv =====
// Controller: raster position counters, window emission decision,
// sequencing of the datapath and output valid. Depends on rds_pkg.
`default_nettype none

module rds_ctrl
	import rds_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [CFG_DIM_W-1:0]         grid_width,
	input  wire logic [CFG_DIM_W-1:0]         grid_height,
	input  wire logic                         in_valid,
	output      logic                         in_stall,
	output      logic                         out_valid,
	input  wire logic                         out_stall,
	output      cmd_t                         cmd,
	output      logic [$clog2(MAX_WIDTH)-1:0] col
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WX_W  = ($clog2(MAX_WIDTH + 1) > CFG_DIM_W) ?
	                       $clog2(MAX_WIDTH + 1) : CFG_DIM_W;
	localparam int HX_W  = ($clog2(MAX_HEIGHT + 1) > CFG_DIM_W) ?
	                       $clog2(MAX_HEIGHT + 1) : CFG_DIM_W;

	state_t        state_q, state_d;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          emit_q, last_q, out_valid_q;

	logic [WX_W-1:0] eff_w, gw, col_x, col_inc;
	logic [HX_W-1:0] eff_h, gh, row_x, row_inc;
	logic            emit_now, last_now, out_free;

	always_comb begin
		gw = WX_W'(grid_width);
		gh = HX_W'(grid_height);
		priority if (gw < WX_W'(DIM_MIN)) begin
			eff_w = WX_W'(DIM_MIN);
		end else if (gw > WX_W'(MAX_WIDTH)) begin
			eff_w = WX_W'(MAX_WIDTH);
		end else begin
			eff_w = gw;
		end
		priority if (gh < HX_W'(DIM_MIN)) begin
			eff_h = HX_W'(DIM_MIN);
		end else if (gh > HX_W'(MAX_HEIGHT)) begin
			eff_h = HX_W'(MAX_HEIGHT);
		end else begin
			eff_h = gh;
		end
	end

	assign col_x   = WX_W'(col_q);
	assign row_x   = HX_W'(row_q);
	assign col_inc = col_x + WX_W'(1);
	assign row_inc = row_x + HX_W'(1);

	assign emit_now = (row_x >= HX_W'(FIRST_EMIT_POS)) && (col_x >= WX_W'(FIRST_EMIT_POS))
	               && (row_x < eff_h) && (col_x < eff_w);
	assign last_now = (row_x == eff_h - HX_W'(1)) && (col_x == eff_w - WX_W'(1));
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_WIN;
				end
			end
			ST_WIN: state_d = emit_q ? ST_LAP : ST_IDLE;
			ST_LAP: state_d = ST_MUL;
			ST_MUL: state_d = ST_SUM;
			ST_SUM: state_d = ST_FIN;
			ST_FIN: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.win      = (state_q == ST_WIN);
		cmd.lap      = (state_q == ST_LAP);
		cmd.mul      = (state_q == ST_MUL);
		cmd.sum      = (state_q == ST_SUM);
		cmd.fin      = (state_q == ST_FIN);
		cmd.load_out = (state_q == ST_OUT) && out_free;
		cmd.last     = last_q;
		in_stall     = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			emit_q      <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				emit_q <= emit_now;
				last_q <= last_now;
			end
			if (cmd.win) begin
				if (col_inc >= eff_w) begin
					col_q <= '0;
					row_q <= (row_inc >= eff_h) ? '0 : row_inc[RW-1:0];
				end else begin
					col_q <= col_inc[CW-1:0];
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign col       = col_q;

	a_accept_to_win: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == ST_WIN)
		else $error("accepted transaction did not move to window update");

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.win |-> $past(cmd.capture))
		else $error("line store written without preceding read");

	a_compute_needs_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LAP |-> emit_q)
		else $error("update computed for a non-interior cell");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== hw/rtl/reaction_diffusion_stencil.sv =====
// Top level of the reaction-diffusion stencil: configuration registers,
// controller and datapath. Depends on rds_pkg, rds_ctrl, rds_datapath.
//
//  channel | signals                               | accepted when
//  --------+---------------------------------------+--------------------------
//  input   | in_valid, in_stall, u_in, v_in        | in_valid && !in_stall
//  output  | out_valid, out_stall, u_next, v_next, | out_valid && !out_stall
//          | last_in_frame                         |
//  config  | cfg_wr_en, cfg_index, cfg_data        | cfg_wr_en
//
// A border cell is accepted, then goes through the line store read and window shift.
// An interior cell goes through the window shift, then the Laplacian, multiply,
// sum and rounding stages of the one datapath, then the output load.
// The output register frees the input side: a new transaction is taken while a
// result waits; only the output load waits on out_stall.
// Reset clears positions, windows and control and loads the configuration reset values; no clearing pass.
`default_nettype none

module reaction_diffusion_stencil
	import rds_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                     in_valid,
	output      logic                     in_stall,
	input  wire logic signed [DATA_W-1:0] u_in,
	input  wire logic signed [DATA_W-1:0] v_in,
	output      logic                     out_valid,
	input  wire logic                     out_stall,
	output      logic signed [DATA_W-1:0] u_next,
	output      logic signed [DATA_W-1:0] v_next,
	output      logic                     last_in_frame
);

	logic [CFG_DIM_W-1:0] grid_width_q, grid_height_q;
	logic [COEF_W-1:0]    f_coef_q, k_coef_q, diffusion_u_q, diffusion_v_q;

	cmd_t                         cmd;
	logic [$clog2(MAX_WIDTH)-1:0] col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
			f_coef_q      <= FEED_RST;
			k_coef_q      <= KILL_RST;
			diffusion_u_q <= DIFF_U_RST;
			diffusion_v_q <= DIFF_V_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data[CFG_DIM_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_data[CFG_DIM_W-1:0];
				REG_FEED:        f_coef_q      <= cfg_data[COEF_W-1:0];
				REG_KILL:        k_coef_q      <= cfg_data[COEF_W-1:0];
				REG_DIFFUSION_U: diffusion_u_q <= cfg_data[COEF_W-1:0];
				REG_DIFFUSION_V: diffusion_v_q <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	rds_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.grid_width (grid_width_q),
		.grid_height(grid_height_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cmd        (cmd),
		.col        (col)
	);

	rds_datapath #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.col          (col),
		.u_in         (u_in),
		.v_in         (v_in),
		.f_coef       (f_coef_q),
		.k_coef       (k_coef_q),
		.diffusion_u  (diffusion_u_q),
		.diffusion_v  (diffusion_v_q),
		.u_next       (u_next),
		.v_next       (v_next),
		.last_in_frame(last_in_frame)
	);

endmodule

`default_nettype wire

// ===== dv/rds_checker.sv =====
// Checker for the reaction-diffusion stencil: mirrors the register writes,
// predicts each updated interior cell from the accepted grid cells and
// compares it with the output channel. Depends on rds_pkg.
module rds_checker
	import rds_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic signed [DATA_W-1:0] u_in,
	input  logic signed [DATA_W-1:0] v_in,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [DATA_W-1:0] u_next,
	input  logic signed [DATA_W-1:0] v_next,
	input  logic                     last_in_frame,
	output int                       fail_count,
	output int                       pending
);

	typedef struct {
		logic signed [DATA_W-1:0] u;
		logic signed [DATA_W-1:0] v;
		logic                     last;
	} cell_update_t;

	cell_update_t updated_cells[$];
	int errs;

	logic [CFG_DIM_W-1:0] grid_w, grid_h;
	logic [COEF_W-1:0]    feed, kill, diff_u, diff_v;

	logic signed [DATA_W-1:0] u_rows[2][MAX_WIDTH_DEF];
	logic signed [DATA_W-1:0] v_rows[2][MAX_WIDTH_DEF];
	logic signed [DATA_W-1:0] u_win[9];
	logic signed [DATA_W-1:0] v_win[9];
	logic [9:0] col_pos, row_pos;

	function automatic int fit_dim(input int dim, input int hi);
		if (dim < DIM_MIN)
			return DIM_MIN;
		if (dim > hi)
			return hi;
		return dim;
	endfunction

	function automatic logic signed [DATA_W-1:0] round_sat(input longint centre,
			input longint delta);
		longint t;
		t = (centre <<< FRAC_SH) + delta + (longint'(1) <<< (FRAC_SH - 1));
		t = t >>> FRAC_SH;
		if (t > Q_MAX)
			t = Q_MAX;
		else if (t < Q_MIN)
			t = Q_MIN;
		return t[DATA_W-1:0];
	endfunction

	task automatic clear_state();
		grid_w = GRID_WIDTH_RST;
		grid_h = GRID_HEIGHT_RST;
		feed = FEED_RST;
		kill = KILL_RST;
		diff_u = DIFF_U_RST;
		diff_v = DIFF_V_RST;
		for (int i = 0; i < 9; i++) begin
			u_win[i] = '0;
			v_win[i] = '0;
		end
		col_pos = '0;
		row_pos = '0;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_GRID_WIDTH: grid_w = data[CFG_DIM_W-1:0];
			REG_GRID_HEIGHT: grid_h = data[CFG_DIM_W-1:0];
			REG_FEED: feed = data;
			REG_KILL: kill = data;
			REG_DIFFUSION_U: diff_u = data;
			REG_DIFFUSION_V: diff_v = data;
			default: ;
		endcase
	endtask

	task automatic gray_scott_step(input logic signed [DATA_W-1:0] ui,
			input logic signed [DATA_W-1:0] vi);
		int w, h, ci;
		longint uc, vc, uvv, du, dv, lap_u, lap_v;
		cell_update_t upd;
		w = fit_dim(int'(grid_w), MAX_WIDTH_DEF);
		h = fit_dim(int'(grid_h), MAX_HEIGHT_DEF);
		ci = int'(col_pos) % MAX_WIDTH_DEF;
		for (int k = 0; k < 3; k++) begin
			u_win[k*3] = u_win[k*3+1];
			u_win[k*3+1] = u_win[k*3+2];
			v_win[k*3] = v_win[k*3+1];
			v_win[k*3+1] = v_win[k*3+2];
		end
		u_win[2] = u_rows[0][ci];
		u_win[5] = u_rows[1][ci];
		u_win[8] = ui;
		v_win[2] = v_rows[0][ci];
		v_win[5] = v_rows[1][ci];
		v_win[8] = vi;
		u_rows[0][ci] = u_rows[1][ci];
		u_rows[1][ci] = ui;
		v_rows[0][ci] = v_rows[1][ci];
		v_rows[1][ci] = vi;

		if (row_pos >= FIRST_EMIT_POS && col_pos >= FIRST_EMIT_POS &&
				int'(row_pos) < h && int'(col_pos) < w) begin
			uc = u_win[4];
			vc = v_win[4];
			lap_u = 0;
			lap_v = 0;
			for (int k = 0; k < 9; k++) begin
				lap_u += u_win[k];
				lap_v += v_win[k];
			end
			lap_u -= 9 * uc;
			lap_v -= 9 * vc;
			uvv = uc * vc * vc;
			du = longint'(diff_u) * lap_u * 256 - uvv
				+ longint'(feed) * (ONE_Q12 - uc) * 256;
			dv = longint'(diff_v) * lap_v * 256 + uvv
				- (longint'(feed) + longint'(kill)) * vc * 256;
			upd.u = round_sat(uc, du);
			upd.v = round_sat(vc, dv);
			upd.last = (int'(row_pos) == h - 1) && (int'(col_pos) == w - 1);
			updated_cells.push_back(upd);
		end

		if (int'(col_pos) + 1 >= w) begin
			col_pos = '0;
			row_pos = (int'(row_pos) + 1 >= h) ? '0 : row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
	endtask

	task automatic check_update();
		cell_update_t upd;
		if (updated_cells.size() == 0) begin
			errs++;
			$error("unexpected transaction: u_next %0d v_next %0d last_in_frame %0b",
				u_next, v_next, last_in_frame);
		end else begin
			upd = updated_cells.pop_front();
			if (u_next !== upd.u) begin
				errs++;
				$error("u_next: expected %0d, actual %0d", upd.u, u_next);
			end
			if (v_next !== upd.v) begin
				errs++;
				$error("v_next: expected %0d, actual %0d", upd.v, v_next);
			end
			if (last_in_frame !== upd.last) begin
				errs++;
				$error("last_in_frame: expected %0b, actual %0b", upd.last,
					last_in_frame);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			updated_cells.delete();
			errs = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_wr_en)
				write_register(cfg_index, cfg_data);
			if (out_valid && !out_stall)
				check_update();
			if (in_valid && !in_stall)
				gray_scott_step(u_in, v_in);
			pending <= updated_cells.size();
			fail_count <= errs;
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the reaction-diffusion stencil: clock, reset, grid cell
// stimulus, output stalls and verdict. Depends on rds_pkg, rds_checker and
// reaction_diffusion_stencil.
module tb_top;
	import rds_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 300;
	localparam int SETTLE         = 12;
	localparam int RANDOM_ITEMS   = 240;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic signed [DATA_W-1:0] u_in = '0;
	logic signed [DATA_W-1:0] v_in = '0;
	logic out_stall = 1'b0;
	logic in_stall, out_valid, last_in_frame;
	logic signed [DATA_W-1:0] u_next, v_next;
	int fail_count, pending;

	logic stall_mode = 1'b0;
	logic long_hold_go = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;
	int stall_run = 0;
	int quiet_cycles = 0;

	bit gap_mode;
	int eff_w, eff_h, col, row, cells_sent;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	reaction_diffusion_stencil dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .u_in(u_in), .v_in(v_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.u_next(u_next), .v_next(v_next), .last_in_frame(last_in_frame)
	);

	rds_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .u_in(u_in), .v_in(v_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.u_next(u_next), .v_next(v_next), .last_in_frame(last_in_frame),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin : stall_gen
		int pick;
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (long_hold_go && !hold_done && out_valid) begin
			hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (stall_run > 0) begin
			stall_run <= stall_run - 1;
		end else if (!stall_mode) begin
			out_stall <= 1'b0;
		end else begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				out_stall <= 1'b1;
				stall_run <= $urandom_range(2);
			end else if (pick < 23) begin
				out_stall <= 1'b1;
				stall_run <= $urandom_range(40, 10);
			end else begin
				out_stall <= 1'b0;
				stall_run <= $urandom_range(7);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int fit_dim(input int dim, input int hi);
		if (dim < DIM_MIN)
			return DIM_MIN;
		if (dim > hi)
			return hi;
		return dim;
	endfunction

	function automatic int idle_gap();
		int pick;
		if (!gap_mode)
			return 0;
		pick = $urandom_range(99);
		if (pick < 70)
			return 0;
		if (pick < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_conc();
		case ($urandom_range(9))
			0: return DATA_W'(Q_MAX);
			1: return DATA_W'(Q_MIN);
			2, 3: return DATA_W'($urandom);
			4: return -DATA_W'($urandom_range(ONE_Q12));
			default: return DATA_W'($urandom_range(ONE_Q12));
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] rand_rate(input int typical);
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2, 3: return COEF_W'($urandom);
			default: return COEF_W'($urandom_range(typical));
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic set_config(input int w, input int h, input logic [COEF_W-1:0] f,
			input logic [COEF_W-1:0] k, input logic [COEF_W-1:0] du,
			input logic [COEF_W-1:0] dv);
		logic [CFG_DATA_W-1:0] wd, hd;
		wd = CFG_DATA_W'($urandom);
		hd = CFG_DATA_W'($urandom);
		wd[CFG_DIM_W-1:0] = w[CFG_DIM_W-1:0];
		hd[CFG_DIM_W-1:0] = h[CFG_DIM_W-1:0];
		write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom));
		write_reg(REG_GRID_WIDTH, wd);
		write_reg(REG_GRID_HEIGHT, hd);
		write_reg(REG_FEED, f);
		write_reg(REG_KILL, k);
		write_reg(REG_DIFFUSION_U, du);
		write_reg(REG_DIFFUSION_V, dv);
		cfg_wr_en <= 1'b0;
		eff_w = fit_dim(w & 'h7FF, MAX_WIDTH_DEF);
		eff_h = fit_dim(h & 'h7FF, MAX_HEIGHT_DEF);
	endtask

	task automatic random_config(input int w, input int h);
		set_config(w, h, rand_rate(2000), rand_rate(5000), rand_rate(16384),
			rand_rate(8192));
	endtask

	task automatic send_cell(input logic signed [DATA_W-1:0] u,
			input logic signed [DATA_W-1:0] v);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		u_in <= u;
		v_in <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		cells_sent++;
		if (col + 1 >= eff_w) begin
			col = 0;
			row = (row + 1 >= eff_h) ? 0 : row + 1;
		end else begin
			col++;
		end
	endtask

	task automatic feed(input int n);
		repeat (n) send_cell(rand_conc(), rand_conc());
	endtask

	task automatic finish_frame();
		while (col != 0 || row != 0) send_cell(rand_conc(), rand_conc());
	endtask

	// stop offering and let every predicted cell come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	logic signed [DATA_W-1:0] corner_u[9] = '{16'sh7FFF, 16'sh8000, 16'sh7FFF,
		16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh1000, 16'shFFFF};
	logic signed [DATA_W-1:0] corner_v[9] = '{16'sh8000, 16'sh7FFF, 16'sh0000,
		16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh1000, 16'shFFFF, 16'sh0001};
	logic signed [DATA_W-1:0] flat_u[12] = '{16'sh0000, 16'sh1000, 16'sh0800,
		16'shF000, 16'sh7FFF, 16'sh8000, 16'sh1000, 16'sh0001, 16'shFFFF,
		16'sh0064, 16'shFF9C, 16'sh0000};
	logic signed [DATA_W-1:0] flat_v[12] = '{16'sh1000, 16'sh8000, 16'sh0000,
		16'sh0800, 16'sh7FFF, 16'sh1000, 16'shF000, 16'sh0800, 16'sh0400,
		16'sh8000, 16'sh7FFF, 16'shFFFF};

	initial begin
		int frames, rand_start, w, h;
		gap_mode = 1'b0;
		col = 0;
		row = 0;
		cells_sent = 0;
		eff_w = MAX_WIDTH_DEF;
		eff_h = MAX_HEIGHT_DEF;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturating coefficients on a single-window grid
		set_config(3, 3, '1, '1, '1, '1);
		for (int i = 0; i < 9; i++) send_cell(corner_u[i], corner_v[i]);
		drain();
		// zero coefficients, height below the minimum
		set_config(4, 0, '0, '0, '0, '0);
		for (int i = 0; i < 12; i++) send_cell(flat_u[i], flat_v[i]);
		drain();

		frames = 0;
		rand_start = cells_sent;
		while (cells_sent - rand_start < RANDOM_ITEMS) begin
			case ($urandom_range(9))
				0: w = $urandom_range(2);
				1: w = $urandom_range(40, 13);
				default: w = $urandom_range(12, 3);
			endcase
			h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
			random_config(w, h);
			gap_mode = ($urandom_range(3) != 0);
			stall_mode <= ($urandom_range(3) != 0);
			if (frames == 3) begin
				feed(eff_w * eff_h / 2);
				drain();
				finish_frame();
			end else begin
				feed(eff_w * eff_h);
			end
			drain();
			frames++;
		end

		// widest grid setting, cut after a few cells by a narrow width
		random_config(2047, 3);
		feed(3);
		drain();
		random_config(3, 4);
		finish_frame();
		drain();

		// tallest grid with one long output hold, cut short by a height change
		random_config(3, 2047);
		gap_mode = 1'b1;
		stall_mode <= 1'b1;
		long_hold_go <= 1'b1;
		feed(3 * 25);
		drain();
		random_config(3, 3);
		finish_frame();
		drain();

		// width shrinks while the column is past the new width
		random_config(9, 8);
		feed(9 * 4 + 7);
		drain();
		random_config(5, 8);
		finish_frame();
		drain();

		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/rds_pkg.sv
hw/rtl/rds_ram.sv
hw/rtl/rds_datapath.sv
hw/rtl/rds_ctrl.sv
hw/rtl/reaction_diffusion_stencil.sv
dv/rds_checker.sv
dv/tb_top.sv
